/* hdl/atc_pkg.sv */
package atc_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W = 17;
    localparam int NOW_W  = 20;
    localparam int PEND_W = 5;

    localparam logic       CMD_INSERT  = 1'b0;
    localparam logic       CMD_TICK    = 1'b1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_BAD_TIME = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_FIRED    = 3'd3;
    localparam logic [2:0] ST_IDLE     = 3'd4;

    localparam logic [6:0] MAX_HOUR    = 7'd23;
    localparam logic [6:0] MAX_MINUTE  = 7'd59;

    typedef struct packed {
        logic       command;
        logic [7:0] alarm_id;
        logic [6:0] alarm_hour;
        logic [6:0] alarm_minute;
        logic [6:0] alarm_second;
        logic [7:0] clock_hours_bcd;
        logic [7:0] clock_minutes_bcd;
        logic [7:0] clock_seconds_bcd;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        fired_id;
        logic              last;
        logic [PEND_W-1:0] pending_count;
    } t_out_item;

    typedef struct packed {
        logic [7:0]        alarm_id;
        logic [TIME_W-1:0] alarm_time;
    } t_entry;

    // packed bcd byte to binary, digits taken as they stand
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return {4'd0, b[3:0]} + ((hi << 3) + (hi << 1));
    endfunction

endpackage

/* hdl/alarm_table_time_compare_unit.sv */
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+-----------------------
// input    | i_in_valid  | o_in_stall  | i_in  (t_in_item)
// result   | o_out_valid | i_out_stall | o_out (t_out_item)
//
// insert: one result transaction with last set
// tick: capture, then one entry per cycle from the table memory while the result side takes fired
//   entries, then a closing step that waits while the result side stalls
// the table memory is read one entry per cycle unless a walk stalls, addressed from the next pointer
// reset clears the entry count and the handshake state, not the table memory
// a new transaction is taken only while no walk runs and the result register is empty or draining
module alarm_table_time_compare_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  atc_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output atc_pkg::t_out_item o_out
);
    import atc_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    // control state
    logic             r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_hold_valid, n_hold_valid;
    logic             r_out_valid;

    // walk state and payload
    logic [CNT_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_wr, n_wr;
    logic [RES_W-1:0] r_n, n_n;
    logic [NOW_W-1:0] r_now, n_now;
    logic [7:0]       r_hold_id, n_hold_id;
    logic [CNT_W-1:0] r_hold_pend, n_hold_pend;
    t_out_item        r_out;

    // table memory
    t_entry           r_mem [TABLE_DEPTH];
    t_entry           r_rdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    logic             out_free;
    logic             in_accept;
    logic             out_load;
    t_out_item        out_item;

    logic             bad_time;
    logic [NOW_W-1:0] ins_time;
    logic [NOW_W-1:0] tick_now;
    logic             due;
    logic [CNT_W-1:0] ins_count;

    // result register can take a new transaction this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign bad_time = (i_in.alarm_hour > MAX_HOUR) || (i_in.alarm_minute > MAX_MINUTE)
                   || (i_in.alarm_second > MAX_MINUTE);

    // seconds since midnight from decimal fields
    assign ins_time = NOW_W'(i_in.alarm_hour) * NOW_W'(3600)
                    + NOW_W'(i_in.alarm_minute) * NOW_W'(60)
                    + NOW_W'(i_in.alarm_second);

    // current time from bcd, may run past one day on bad digits
    assign tick_now = NOW_W'(bcd_to_bin(i_in.clock_hours_bcd)) * NOW_W'(3600)
                    + NOW_W'(bcd_to_bin(i_in.clock_minutes_bcd)) * NOW_W'(60)
                    + NOW_W'(bcd_to_bin(i_in.clock_seconds_bcd));

    assign due = (NOW_W'(r_rdata.alarm_time) <= r_now) && (r_n < RES_W'(MAX_RESULTS));

    assign ins_count = r_count + CNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd         = r_rd;
        n_wr         = r_wr;
        n_n          = r_n;
        n_now        = r_now;
        n_hold_valid = r_hold_valid;
        n_hold_id    = r_hold_id;
        n_hold_pend  = r_hold_pend;
        mem_we       = 1'b0;
        mem_waddr    = r_wr[IDX_W-1:0];
        mem_wdata    = r_rdata;
        out_load     = 1'b0;
        out_item     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in.command == CMD_INSERT) begin
                        out_load      = 1'b1;
                        out_item.last = 1'b1;
                        if (bad_time) begin
                            out_item.status = ST_BAD_TIME;
                        end else if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                            out_item.status = ST_FULL;
                        end else begin
                            // append at the end of the table
                            mem_we               = 1'b1;
                            mem_waddr            = r_count[IDX_W-1:0];
                            mem_wdata.alarm_id   = i_in.alarm_id;
                            mem_wdata.alarm_time = ins_time[TIME_W-1:0];
                            n_count              = ins_count;
                            out_item.status      = ST_INSERTED;
                        end
                        out_item.pending_count = PEND_W'(n_count);
                    end else begin
                        // start a walk from entry 0
                        n_now        = tick_now;
                        n_rd         = '0;
                        n_wr         = '0;
                        n_n          = '0;
                        n_hold_valid = 1'b0;
                        n_state      = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_rd == r_count) begin
                    // closing cycle: last result out, count set to entries kept
                    if (out_free) begin
                        out_load      = 1'b1;
                        out_item.last = 1'b1;
                        if (r_hold_valid) begin
                            out_item.status        = ST_FIRED;
                            out_item.fired_id      = r_hold_id;
                            out_item.pending_count = PEND_W'(r_hold_pend);
                        end else begin
                            out_item.status        = ST_IDLE;
                            out_item.pending_count = PEND_W'(r_wr);
                        end
                        n_count      = r_wr;
                        n_hold_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end else if (due) begin
                    // a fired alarm waits in the hold slot until we know
                    // whether another follows
                    if (!r_hold_valid || out_free) begin
                        if (r_hold_valid) begin
                            out_load               = 1'b1;
                            out_item.status        = ST_FIRED;
                            out_item.fired_id      = r_hold_id;
                            out_item.pending_count = PEND_W'(r_hold_pend);
                        end
                        n_hold_valid = 1'b1;
                        n_hold_id    = r_rdata.alarm_id;
                        n_hold_pend  = r_count - CNT_W'(r_n) - CNT_W'(1);
                        n_n          = r_n + RES_W'(1);
                        n_rd         = r_rd + CNT_W'(1);
                    end
                end else begin
                    // keep the entry, moved up to close any gap
                    mem_we = 1'b1;
                    n_wr   = r_wr + CNT_W'(1);
                    n_rd   = r_rd + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // read from the next pointer; during a walk, writes land at or below the entry in hand,
    // so they never hit the address being read
    assign mem_raddr = n_rd[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_hold_valid <= n_hold_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd        <= n_rd;
        r_wr        <= n_wr;
        r_n         <= n_n;
        r_now       <= n_now;
        r_hold_id   <= n_hold_id;
        r_hold_pend <= n_hold_pend;
        if (out_load) begin
            r_out <= out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // table never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // every entry read so far was either fired or kept
    a_walk_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (CNT_W'(r_n) + r_wr == r_rd))
        else $error("walk counters out of balance");

    // walk pointer never passes the entry count
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_rd <= r_count))
        else $error("walk pointer past entry count");

    // an idle result only closes a walk that fired nothing
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status == ST_IDLE))
            |-> (o_out.last && (o_out.fired_id == 8'd0)))
        else $error("idle result without last");

endmodule
